// ===== rtl/core/qnpd_pkg.sv =====
// Shared types and constants for the QAM16 nearest point demapper
`timescale 1ns / 1ps

package qnpd_pkg;

   // Number of points that take part in the search (2 to 16)
   localparam int NUM_POINTS  = 16;
   localparam int MAX_POINTS  = 16;
   localparam int IDX_W       = 4;
   localparam int NUM_WORDS   = 8;
   localparam int WORD_W      = 64;
   localparam int CSR_IDX_W   = 4;
   localparam int SAMPLE_W    = 16;
   localparam int POINT_W     = 2 * SAMPLE_W;
   localparam int DIFF_W      = SAMPLE_W + 1;
   localparam int SQ_W        = 2 * SAMPLE_W;
   localparam int DIST_W      = SQ_W + 1;

   // Pipeline shape: difference, square, sum, then one stage per tree level
   localparam int DIST_STAGES = 3;
   localparam int TREE_LEVELS = 4;
   localparam int NUM_NODES   = MAX_POINTS - 1;
   localparam int LATENCY     = DIST_STAGES + TREE_LEVELS;

   // Register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] REG_POINTS_0_1   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_POINTS_2_3   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_POINTS_4_5   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_POINTS_6_7   = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_POINTS_8_9   = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] REG_POINTS_10_11 = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] REG_POINTS_12_13 = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] REG_POINTS_14_15 = CSR_IDX_W'(7);

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [DIFF_W-1:0]   diff_type;
   typedef logic [DIST_W-1:0]          dist_type;
   typedef logic [IDX_W-1:0]           idx_type;

   typedef struct packed {
      sample_type im;
      sample_type re;
   } point_type;

   typedef struct packed {
      dist_type sq_dist;
      idx_type  idx;
   } cand_type;

   // Pipeline advance and the valid bit entering a section
   typedef struct packed {
      logic en;
      logic valid;
   } pipe_ctl_type;

   // Larger than any real distance: padding lanes never win
   localparam dist_type DIST_MAX = '1;

endpackage

// ===== rtl/core/qnpd_ifs.sv =====
// Channel interfaces: symbol requests, index responses, csr writes
`timescale 1ns / 1ps

interface qnpd_req_if;
   import qnpd_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sym_i;
   sample_type sym_q;
   modport source (output valid, output sym_i, output sym_q, input ready);
   modport sink   (input valid, input sym_i, input sym_q, output ready);
endinterface

interface qnpd_rsp_if;
   import qnpd_pkg::*;
   logic    valid;
   logic    ready;
   idx_type point_index;
   modport source (output valid, output point_index, input ready);
   modport sink   (input valid, input point_index, output ready);
endinterface

interface qnpd_csr_if;
   import qnpd_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [WORD_W-1:0]    data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/qam16_nearest_point_demapper.sv =====
// Top level of the QAM16 nearest point demapper
//
//   channel  dir  handshake       payload
//   req_ch   in   valid / ready   sym_i, sym_q (signed Q1.15)
//   rsp_ch   out  valid / ready   point_index (4 bits)
//   csr_ch   in   valid / ready   index (4 bits), data (64 bits)
//
// One request per cycle unless rsp_ch stalls; each request passes through 3 distance
// stages, then 4 compare tree levels, before its response appears.
// A response held on rsp_ch freezes the whole pipeline and drops req_ch.ready;
// nothing is lost or repeated. csr_ch is always ready.
// Reset clears all valid bits and sets every point word to zero.
`timescale 1ns / 1ps

module qam16_nearest_point_demapper (
   input logic        clock,
   input logic        reset,
   qnpd_req_if.sink   req_ch,
   qnpd_rsp_if.source rsp_ch,
   qnpd_csr_if.sink   csr_ch
);
   import qnpd_pkg::*;

   logic [WORD_W-1:0] words_ff [NUM_WORDS];
   logic [WORD_W-1:0] words_in [NUM_WORDS];
   point_type         points   [MAX_POINTS];
   dist_type          sq_dist  [MAX_POINTS];
   pipe_ctl_type      dist_ctl;
   pipe_ctl_type      tree_ctl;
   logic              dist_valid;
   logic              advance;

   // Point word writes
   always_comb begin
      words_in = words_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_POINTS_0_1:   words_in[0] = csr_ch.data;
            REG_POINTS_2_3:   words_in[1] = csr_ch.data;
            REG_POINTS_4_5:   words_in[2] = csr_ch.data;
            REG_POINTS_6_7:   words_in[3] = csr_ch.data;
            REG_POINTS_8_9:   words_in[4] = csr_ch.data;
            REG_POINTS_10_11: words_in[5] = csr_ch.data;
            REG_POINTS_12_13: words_in[6] = csr_ch.data;
            REG_POINTS_14_15: words_in[7] = csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < NUM_WORDS; w++) begin
            words_ff[w] <= '0;
         end
      end else begin
         words_ff <= words_in;
      end
   end

   assign csr_ch.ready = 1'b1;

   // Unpack two points per word
   for (genvar k = 0; k < MAX_POINTS; k++) begin : g_unpack
      localparam int WORD = k / 2;
      localparam int LSB  = (k % 2) * POINT_W;
      assign points[k] = point_type'(words_ff[WORD][LSB +: POINT_W]);
   end

   // Whole pipeline moves unless the output holds an untaken response
   assign advance      = !(rsp_ch.valid && !rsp_ch.ready);
   assign req_ch.ready = advance;

   assign dist_ctl.en    = advance;
   assign dist_ctl.valid = req_ch.valid;
   assign tree_ctl.en    = advance;
   assign tree_ctl.valid = dist_valid;

   qnpd_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (dist_ctl),
      .sym_i     (req_ch.sym_i),
      .sym_q     (req_ch.sym_q),
      .points    (points),
      .sq_dist   (sq_dist),
      .valid_out (dist_valid)
   );

   qnpd_tree u_tree (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (tree_ctl),
      .sq_dist   (sq_dist),
      .idx_out   (rsp_ch.point_index),
      .valid_out (rsp_ch.valid)
   );

endmodule

// ===== rtl/core/qnpd_dist.sv =====
// Distance lanes: difference, square and sum stages for every point
`timescale 1ns / 1ps

module qnpd_dist (
   input  logic                   clock,
   input  logic                   reset,
   input  qnpd_pkg::pipe_ctl_type ctl_in,
   input  qnpd_pkg::sample_type   sym_i,
   input  qnpd_pkg::sample_type   sym_q,
   input  qnpd_pkg::point_type    points [qnpd_pkg::MAX_POINTS],
   output qnpd_pkg::dist_type     sq_dist [qnpd_pkg::MAX_POINTS],
   output logic                   valid_out
);
   import qnpd_pkg::*;

   logic [DIST_STAGES-1:0] valid_ff;
   logic [DIST_STAGES-1:0] valid_in;

   // Valid bits move with the data
   always_comb begin
      valid_in = {valid_ff[DIST_STAGES-2:0], ctl_in.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl_in.en) begin
         valid_ff <= valid_in;
      end
   end

   assign valid_out = valid_ff[DIST_STAGES-1];

   for (genvar k = 0; k < MAX_POINTS; k++) begin : g_lane
      if (k < NUM_POINTS) begin : g_used
         diff_type                   diff_re_ff, diff_re_in;
         diff_type                   diff_im_ff, diff_im_in;
         logic signed [2*DIFF_W-1:0] prod_re, prod_im;
         logic [SQ_W-1:0]            sq_re_ff, sq_re_in;
         logic [SQ_W-1:0]            sq_im_ff, sq_im_in;
         dist_type                   dist_ff, dist_in;

         // Point minus symbol, exact in 17 bits
         assign diff_re_in = diff_type'(points[k].re) - diff_type'(sym_i);
         assign diff_im_in = diff_type'(points[k].im) - diff_type'(sym_q);

         // Squares are nonnegative and below 2^32
         assign prod_re  = diff_re_ff * diff_re_ff;
         assign prod_im  = diff_im_ff * diff_im_ff;
         assign sq_re_in = prod_re[SQ_W-1:0];
         assign sq_im_in = prod_im[SQ_W-1:0];

         assign dist_in = {1'b0, sq_re_ff} + {1'b0, sq_im_ff};

         always_ff @(posedge clock) begin
            if (ctl_in.en) begin
               diff_re_ff <= diff_re_in;
               diff_im_ff <= diff_im_in;
               sq_re_ff   <= sq_re_in;
               sq_im_ff   <= sq_im_in;
               dist_ff    <= dist_in;
            end
         end

         assign sq_dist[k] = dist_ff;
      end else begin : g_pad
         assign sq_dist[k] = DIST_MAX;
      end
   end

endmodule

// ===== rtl/core/qnpd_tree.sv =====
// Registered minimum tree over the point distances, lower index wins ties
`timescale 1ns / 1ps

module qnpd_tree (
   input  logic                   clock,
   input  logic                   reset,
   input  qnpd_pkg::pipe_ctl_type ctl_in,
   input  qnpd_pkg::dist_type     sq_dist [qnpd_pkg::MAX_POINTS],
   output qnpd_pkg::idx_type      idx_out,
   output logic                   valid_out
);
   import qnpd_pkg::*;

   cand_type               leaf    [MAX_POINTS];
   cand_type               node_ff [NUM_NODES];
   cand_type               node_in [NUM_NODES];
   logic [TREE_LEVELS-1:0] valid_ff;
   logic [TREE_LEVELS-1:0] valid_in;

   // Leaves carry their own index
   for (genvar k = 0; k < MAX_POINTS; k++) begin : g_leaf
      assign leaf[k].sq_dist = sq_dist[k];
      assign leaf[k].idx     = IDX_W'(k);
   end

   // Heap layout: node i has children 2i+1 and 2i+2, leaves follow the nodes
   for (genvar i = 0; i < NUM_NODES; i++) begin : g_node
      localparam int LC = 2 * i + 1;
      localparam int RC = 2 * i + 2;
      cand_type lc, rc;

      if (LC >= NUM_NODES) begin : g_lc_leaf
         assign lc = leaf[LC-NUM_NODES];
      end else begin : g_lc_node
         assign lc = node_ff[LC];
      end

      if (RC >= NUM_NODES) begin : g_rc_leaf
         assign rc = leaf[RC-NUM_NODES];
      end else begin : g_rc_node
         assign rc = node_ff[RC];
      end

      // Right side holds higher indices: it wins only when strictly closer
      assign node_in[i] = (rc.sq_dist < lc.sq_dist) ? rc : lc;
   end

   always_comb begin
      valid_in = {valid_ff[TREE_LEVELS-2:0], ctl_in.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl_in.en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_in.en) begin
         node_ff <= node_in;
      end
   end

   assign idx_out   = node_ff[0].idx;
   assign valid_out = valid_ff[TREE_LEVELS-1];

endmodule

// ===== rtl/core/qnpd_checker.sv =====
// Port-level assertions for the demapper, bound to the top level
`timescale 1ns / 1ps

module qnpd_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input qnpd_pkg::idx_type   point_index
);
   import qnpd_pkg::*;

   // A held response keeps its index
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(point_index))
      else $error("response changed while stalled");

   // Requests are refused exactly when a response is stalled
   a_req_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == !(rsp_valid && !rsp_ready))
      else $error("req ready does not follow output stall");

   // No response right after reset
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response present after reset");

   // Only points that take part can be chosen
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(point_index) < NUM_POINTS))
      else $error("point index out of range");

   // Without stalls a request comes out after the pipeline latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $past(req_valid && req_ready, 7) && !$past(reset, 1) && !$past(reset, 2)
      && !$past(reset, 3) && !$past(reset, 4) && !$past(reset, 5)
      && !$past(reset, 6) && $past(rsp_ready, 1) && $past(rsp_ready, 2)
      && $past(rsp_ready, 3) && $past(rsp_ready, 4) && $past(rsp_ready, 5)
      && $past(rsp_ready, 6) |-> rsp_valid)
      else $error("response missing after pipeline latency");

endmodule

bind qam16_nearest_point_demapper qnpd_checker u_qnpd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .point_index (rsp_ch.point_index)
);
